// File: src/mpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Media packet deframer package
// Shared constants, result kinds and the result record.
// ----------------------------------------------------------------------------
package mpd_pkg;

  localparam int unsigned HdrLen        = 28;
  localparam int unsigned HdrIdxW       = $clog2(HdrLen);
  localparam int unsigned SizeW         = 31;
  localparam logic [SizeW-1:0] MaxSizeReset = 31'd100000000;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [63:0] present_time;
    logic signed [63:0] decode_time;
    logic signed [31:0] stream_number;
    logic signed [31:0] packet_flags;
    logic [SizeW-1:0]   payload_size;
    logic [7:0]         payload_byte;
    logic               last_byte;
  } result_t;

endpackage

// File: src/mpd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Media packet deframer parser
// Gathers the header, checks the size and counts payload bytes per item.
// ----------------------------------------------------------------------------
module mpd_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  logic [7:0]                 byte_i,
  input  logic [mpd_pkg::SizeW-1:0]  max_size_i,
  output logic                       res_valid_o,
  output mpd_pkg::result_t           res_o
);
  import mpd_pkg::*;

  localparam int unsigned StoreLen = HdrLen - 1;
  localparam logic [HdrIdxW-1:0] LastIdx = HdrIdxW'(HdrLen - 1);

  logic [HdrIdxW-1:0] idx_q, idx_d;
  logic [SizeW-1:0]   rem_q, rem_d;
  logic               halted_q, halted_d;
  logic [7:0]         hdr_q [StoreLen];
  logic               shift_en;
  logic [8*HdrLen-1:0] hdr_flat;
  logic [31:0]        size_raw;
  logic               size_bad;

  always_comb begin
    for (int k = 0; k < StoreLen; k++) begin
      hdr_flat[8*k +: 8] = hdr_q[k];
    end
    hdr_flat[8*StoreLen +: 8] = byte_i;
  end

  assign size_raw = hdr_flat[8*24 +: 32];
  assign size_bad = size_raw[31] || (size_raw == 32'd0) ||
                    (size_raw[SizeW-1:0] > max_size_i);

  always_comb begin
    idx_d       = idx_q;
    rem_d       = rem_q;
    halted_d    = halted_q;
    shift_en    = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.kind  = KIND_HEADER;
    if (fire_i && !halted_q) begin
      if (rem_q != '0) begin
        res_valid_o        = 1'b1;
        res_o.kind         = KIND_PAYLOAD;
        res_o.payload_byte = byte_i;
        res_o.last_byte    = (rem_q == SizeW'(1));
        rem_d              = rem_q - SizeW'(1);
      end else if (idx_q == LastIdx) begin
        idx_d       = '0;
        res_valid_o = 1'b1;
        if (size_bad) begin
          res_o.kind = KIND_ERROR;
          halted_d   = 1'b1;
        end else begin
          res_o.kind          = KIND_HEADER;
          res_o.present_time  = hdr_flat[0 +: 64];
          res_o.decode_time   = hdr_flat[64 +: 64];
          res_o.stream_number = hdr_flat[128 +: 32];
          res_o.packet_flags  = hdr_flat[160 +: 32];
          res_o.payload_size  = size_raw[SizeW-1:0];
          rem_d               = size_raw[SizeW-1:0];
        end
      end else begin
        shift_en = 1'b1;
        idx_d    = idx_q + HdrIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      rem_q    <= '0;
      halted_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      rem_q    <= rem_d;
      halted_q <= halted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int k = 0; k < StoreLen - 1; k++) begin
        hdr_q[k] <= hdr_q[k+1];
      end
      hdr_q[StoreLen-1] <= byte_i;
    end
  end

`ifndef SYNTHESIS
  a_halt_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("Halt flag cleared without reset.");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LastIdx)
    else $error("Header index out of range.");

  a_no_hdr_in_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q != '0) |-> (idx_q == '0))
    else $error("Header bytes gathered during payload.");

  a_halted_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> !res_valid_o)
    else $error("Result produced while halted.");
`endif

endmodule

// File: src/mpd_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Media packet deframer result register
// Holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module mpd_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  mpd_pkg::result_t res_i,
  input  logic             out_ready_i,
  output logic             space_o,
  output logic             out_valid_o,
  output mpd_pkg::result_t res_o
);
  import mpd_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign space_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> space_o)
    else $error("Result register loaded while full.");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> valid_q)
    else $error("Loaded item not presented.");

  a_hold_unloaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_ready_i && !load_i) |=> (valid_q && $stable(res_q)))
    else $error("Pending item lost.");
`endif

endmodule

// File: src/media_packet_deframer.sv
`timescale 1ns / 1ps
// Output: a result item is presented in the cycle after the input item that causes it.
// Throughput: one input item per cycle while the result register has space; the
// result register frees itself in the same cycle that the consumer takes its item.
// Reset: asynchronous, active low; clears the header count, the payload count,
// the halt flag and the result valid, and loads the size limit with 100000000.
// ----------------------------------------------------------------------------
// Media packet deframer
// Splits a byte stream into header descriptors and payload bytes.
// ----------------------------------------------------------------------------
module media_packet_deframer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                in_byte_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [mpd_pkg::SizeW-1:0] max_payload_size_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                kind_o,
  output logic signed [63:0]        present_time_o,
  output logic signed [63:0]        decode_time_o,
  output logic signed [31:0]        stream_number_o,
  output logic signed [31:0]        packet_flags_o,
  output logic [mpd_pkg::SizeW-1:0] payload_size_o,
  output logic [7:0]                payload_byte_o,
  output logic                      last_byte_o
);
  import mpd_pkg::*;

  logic [SizeW-1:0] max_size_q;
  logic             in_fire;
  logic             res_valid;
  logic             space;
  result_t          res;
  result_t          out_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_size_q <= MaxSizeReset;
    end else if (cfg_valid_i) begin
      max_size_q <= max_payload_size_i;
    end
  end

  assign in_ready_o = space;
  assign in_fire    = in_valid_i && space;

  mpd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (in_fire),
    .byte_i      (in_byte_i),
    .max_size_i  (max_size_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mpd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .out_ready_i (out_ready_i),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign kind_o          = out_res.kind;
  assign present_time_o  = out_res.present_time;
  assign decode_time_o   = out_res.decode_time;
  assign stream_number_o = out_res.stream_number;
  assign packet_flags_o  = out_res.packet_flags;
  assign payload_size_o  = out_res.payload_size;
  assign payload_byte_o  = out_res.payload_byte;
  assign last_byte_o     = out_res.last_byte;

endmodule
